>>> hdl/chon_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chon_pkg
// Shared sizes, command and configuration types and Q8.24 helpers of the
// coupled Hopf oscillator network.
// ----------------------------------------------------------------------------
package chon_pkg;

    localparam int NUM_OSC     = 8;
    localparam int IDX_W       = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
    localparam int PAIRS       = NUM_OSC * NUM_OSC;
    localparam int PAIR_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int MAX_RES     = 8;
    localparam int REPORT_N    = (NUM_OSC < MAX_RES) ? NUM_OSC : MAX_RES;
    localparam int ACC_W       = 32 + IDX_W + 1;
    localparam int SAT_W       = 72;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int DIV_STEPS   = 31;
    localparam int DCNT_W      = 5;

    localparam int IN_W        = 192;
    localparam int OUT_W       = 72;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    localparam logic [1:0] FUNC_PAIR = 2'd0;
    localparam logic [1:0] FUNC_OSC  = 2'd1;
    localparam logic [1:0] FUNC_STEP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd4;

    typedef enum logic [1:0] {OP_PAIR, OP_OSC, OP_STEP} t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   row;
        logic [PAIR_W-1:0]  pair;
        logic signed [31:0] weight;
        logic signed [25:0] cos_p;
        logic signed [25:0] sin_p;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic [30:0]        radius;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] lambda;
        logic signed [31:0] omega;
        logic signed [31:0] sigma;
        logic [30:0]        h;
        logic signed [31:0] gain;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [31:0] r;
        if (x > SAT_W'(Q_MAX)) begin
            r = Q_MAX;
        end else if (x < SAT_W'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
        return sat32(SAT_W'(p >>> 24));
    endfunction

endpackage

>>> hdl/chon_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chon_div
// Restoring divider giving floor(num * 2^24 / den) saturated to Q8.24 max,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module chon_div import chon_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_num,
    input  logic [63:0]        i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [31:0] o_quo
);

    logic                r_busy;
    logic                r_done;
    logic [63:0]         r_rem;
    logic [63:0]         r_den;
    logic [DIV_STEPS-1:0] r_bits;
    logic [DIV_STEPS-1:0] r_quo;
    logic [DCNT_W-1:0]   r_cnt;
    logic [64:0]         n_trial;
    logic                n_fit;

    assign n_trial = {r_rem, r_bits[DIV_STEPS-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                if ((i_num >> 7) >= i_den) begin
                    r_quo  <= '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem  <= i_num >> 7;
                    r_bits <= {i_num[6:0], 24'd0};
                    r_cnt  <= DCNT_W'(DIV_STEPS - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= n_fit ? n_trial[63:0] - r_den : n_trial[63:0];
                r_quo  <= {r_quo[DIV_STEPS-2:0], n_fit};
                r_bits <= {r_bits[DIV_STEPS-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = $signed({1'b0, r_quo});

endmodule

>>> hdl/chon_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chon_front
// Accepts requests and configuration writes, drops requests that do nothing
// and queues the rest as commands for the back end.
// ----------------------------------------------------------------------------
module chon_front import chon_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_cfg                 o_cfg,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    t_cfg        r_cfg;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        row_ok;
    logic        col_ok;
    logic        keep;

    assign row    = s_axis_tdata[2:0];
    assign col    = s_axis_tdata[5:3];
    assign row_ok = 32'(row) < NUM_OSC;
    assign col_ok = 32'(col) < NUM_OSC;

    always_comb begin
        o_cmd        = '0;
        o_cmd.row    = IDX_W'(row);
        o_cmd.pair   = PAIR_W'(32'(row) * NUM_OSC + 32'(col));
        o_cmd.weight = $signed(s_axis_tdata[37:6]);
        o_cmd.cos_p  = $signed(s_axis_tdata[63:38]);
        o_cmd.sin_p  = $signed(s_axis_tdata[89:64]);
        o_cmd.u      = $signed(s_axis_tdata[121:90]);
        o_cmd.v      = $signed(s_axis_tdata[153:122]);
        o_cmd.radius = (s_axis_tdata[184:154] == '0) ? 31'd1 : s_axis_tdata[184:154];
        keep         = 1'b0;
        unique case (s_axis_tuser)
            FUNC_PAIR: begin
                o_cmd.op = OP_PAIR;
                keep     = row_ok && col_ok;
            end
            FUNC_OSC: begin
                o_cmd.op = OP_OSC;
                keep     = row_ok;
            end
            FUNC_STEP: begin
                o_cmd.op = OP_STEP;
                keep     = 1'b1;
            end
            default: begin
                o_cmd.op = OP_STEP;
                keep     = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lambda <= Q_ONE;
            r_cfg.omega  <= '0;
            r_cfg.sigma  <= Q_ONE;
            r_cfg.h      <= 31'd167772;
            r_cfg.gain   <= Q_ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAMBDA: r_cfg.lambda <= $signed(i_cfg_data);
                CFG_OMEGA:  r_cfg.omega  <= $signed(i_cfg_data);
                CFG_SIGMA:  r_cfg.sigma  <= $signed(i_cfg_data);
                CFG_H:      r_cfg.h      <= i_cfg_data[30:0];
                CFG_GAIN:   r_cfg.gain   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

>>> hdl/chon_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chon_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module chon_queue import chon_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
    end

endmodule

>>> hdl/chon_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chon_back
// Executes queued commands: table and state writes, and the oscillator step
// through a shared multiplier and divider, then reports and commits states.
// ----------------------------------------------------------------------------
module chon_back import chon_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    typedef enum logic [5:0] {
        S_IDLE, S_I_RD, S_I_LD, S_J_RD,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_PDIV, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_TDIV, S_T6, S_T7, S_T8,
        S_T9, S_T10, S_T11, S_T12, S_T13, S_EMIT, S_C_RD, S_C_WR
    } t_state;

    t_state              r_state;

    logic signed [31:0]  u_mem [NUM_OSC];
    logic signed [31:0]  v_mem [NUM_OSC];
    logic [30:0]         rho_mem [NUM_OSC];
    logic [63:0]         nb_mem [NUM_OSC];
    logic signed [31:0]  w_mem [PAIRS];
    logic signed [25:0]  c_mem [PAIRS];
    logic signed [25:0]  s_mem [PAIRS];
    logic [NUM_OSC-1:0]  r_uv_ok;
    logic [NUM_OSC-1:0]  r_rho_ok;
    logic [PAIRS-1:0]    r_pair_ok;

    logic signed [31:0]  r_rd_u, r_rd_v, r_rd_w;
    logic signed [25:0]  r_rd_c, r_rd_s;
    logic [30:0]         r_rd_rho;
    logic [63:0]         r_rd_nb;
    logic                r_rd_uv_ok, r_rd_rho_ok, r_rd_pair_ok;
    logic signed [31:0]  rd_u, rd_v, rd_w, rd_c, rd_s, rd_rho;

    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_saddr;
    logic [PAIR_W-1:0]   r_paddr;
    logic signed [31:0]  r_ui, r_vi, r_rhoi;
    logic signed [63:0]  r_acc;
    logic signed [31:0]  r_ru, r_rv, r_rr, r_eu, r_ev;
    logic signed [ACC_W-1:0] r_accu, r_accv;
    logic signed [31:0]  r_cu, r_cv, r_temp, r_lt, r_du, r_dv, r_nu, r_nv;
    logic signed [33:0]  r_dacc;
    logic [63:0]         r_sq;
    logic signed [63:0]  r_prod;
    logic signed [63:0]  n_prod;
    logic signed [31:0]  mul_a, mul_b;

    logic                r_mvalid;
    logic [OUT_W-1:0]    r_mdata;
    logic                r_mlast;

    logic                wr_pair, wr_osc, wr_commit;
    logic [IDX_W-1:0]    st_wa;
    logic signed [31:0]  st_wu, st_wv;
    logic                div_start, div_busy, div_done;
    logic [63:0]         div_num, div_den;
    logic signed [31:0]  div_q;
    logic                i_last, s_last, report, out_free;
    logic signed [31:0]  h_s;

    assign h_s    = $signed({1'b0, i_cfg.h});
    assign i_last = r_i == IDX_W'(NUM_OSC - 1);
    assign s_last = r_saddr == IDX_W'(NUM_OSC - 1);
    assign report = 32'(r_i) < REPORT_N;
    assign out_free = !r_mvalid || m_axis_tready;

    assign rd_u   = r_rd_uv_ok ? r_rd_u : '0;
    assign rd_v   = r_rd_uv_ok ? r_rd_v : '0;
    assign rd_rho = r_rd_rho_ok ? $signed({1'b0, r_rd_rho}) : Q_ONE;
    assign rd_w   = r_rd_pair_ok ? r_rd_w : '0;
    assign rd_c   = r_rd_pair_ok ? 32'(r_rd_c) : Q_ONE;
    assign rd_s   = r_rd_pair_ok ? 32'(r_rd_s) : '0;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign wr_pair   = o_cmd_pop && (i_cmd.op == OP_PAIR);
    assign wr_osc    = o_cmd_pop && (i_cmd.op == OP_OSC);
    assign wr_commit = r_state == S_C_WR;
    assign st_wa     = wr_commit ? r_saddr : i_cmd.row;
    assign st_wu     = wr_commit ? $signed(r_rd_nb[31:0]) : i_cmd.u;
    assign st_wv     = wr_commit ? $signed(r_rd_nb[63:32]) : i_cmd.v;

    always_ff @(posedge i_clk) begin
        if (wr_osc || wr_commit) begin
            u_mem[st_wa] <= st_wu;
            v_mem[st_wa] <= st_wv;
        end
        if (wr_osc) begin
            rho_mem[st_wa] <= i_cmd.radius;
        end
        if (wr_pair) begin
            w_mem[i_cmd.pair] <= i_cmd.weight;
            c_mem[i_cmd.pair] <= i_cmd.cos_p;
            s_mem[i_cmd.pair] <= i_cmd.sin_p;
        end
        if (r_state == S_EMIT) begin
            nb_mem[r_i] <= {r_nv, r_nu};
        end
        r_rd_u       <= u_mem[r_saddr];
        r_rd_v       <= v_mem[r_saddr];
        r_rd_rho     <= rho_mem[r_saddr];
        r_rd_nb      <= nb_mem[r_saddr];
        r_rd_uv_ok   <= r_uv_ok[r_saddr];
        r_rd_rho_ok  <= r_rho_ok[r_saddr];
        r_rd_w       <= w_mem[r_paddr];
        r_rd_c       <= c_mem[r_paddr];
        r_rd_s       <= s_mem[r_paddr];
        r_rd_pair_ok <= r_pair_ok[r_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_ok   <= '0;
            r_rho_ok  <= '0;
            r_pair_ok <= '0;
        end else begin
            if (wr_osc || wr_commit) begin
                r_uv_ok[st_wa] <= 1'b1;
            end
            if (wr_osc) begin
                r_rho_ok[st_wa] <= 1'b1;
            end
            if (wr_pair) begin
                r_pair_ok[i_cmd.pair] <= 1'b1;
            end
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_P0:  begin mul_a = rd_c;        mul_b = rd_u;   end
            S_P1:  begin mul_a = rd_s;        mul_b = rd_v;   end
            S_P2:  begin mul_a = rd_s;        mul_b = rd_u;   end
            S_P3:  begin mul_a = rd_c;        mul_b = rd_v;   end
            S_P5:  begin mul_a = r_ru;        mul_b = r_rr;   end
            S_P6:  begin mul_a = r_rv;        mul_b = r_rr;   end
            S_P7:  begin mul_a = rd_w;        mul_b = r_eu;   end
            S_P8:  begin mul_a = rd_w;        mul_b = r_ev;   end
            S_T0:  begin mul_a = i_cfg.gain;  mul_b = sat32(SAT_W'(r_accu)); end
            S_T1:  begin mul_a = i_cfg.gain;  mul_b = sat32(SAT_W'(r_accv)); end
            S_T2:  begin mul_a = r_ui;        mul_b = r_ui;   end
            S_T3:  begin mul_a = r_vi;        mul_b = r_vi;   end
            S_T4:  begin mul_a = r_rhoi;      mul_b = r_rhoi; end
            S_T6:  begin mul_a = i_cfg.lambda; mul_b = r_temp; end
            S_T7:  begin mul_a = i_cfg.omega; mul_b = r_vi;   end
            S_T8:  begin mul_a = r_lt;        mul_b = r_ui;   end
            S_T9:  begin mul_a = i_cfg.omega; mul_b = r_ui;   end
            S_T10: begin mul_a = r_lt;        mul_b = r_vi;   end
            S_T11: begin mul_a = r_du;        mul_b = h_s;    end
            S_T12: begin mul_a = r_dv;        mul_b = h_s;    end
            default: ;
        endcase
        n_prod = mul_a * mul_b;
    end

    assign div_start = (r_state == S_P4) || (r_state == S_T5);
    assign div_num   = (r_state == S_T5) ? r_sq : {33'd0, r_rhoi[30:0]};
    assign div_den   = (r_state == S_T5) ? $unsigned(r_prod) : {33'd0, rd_rho[30:0]};

    chon_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= 1'b0;
            r_i      <= '0;
            r_saddr  <= '0;
            r_paddr  <= '0;
        end else begin
            if (m_axis_tready && !((r_state == S_EMIT) && report)) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.op == OP_STEP) begin
                        r_i     <= '0;
                        r_saddr <= '0;
                        r_paddr <= '0;
                        r_state <= S_I_RD;
                    end
                end
                S_I_RD: r_state <= S_I_LD;
                S_I_LD: begin
                    r_ui    <= rd_u;
                    r_vi    <= rd_v;
                    r_rhoi  <= rd_rho;
                    r_accu  <= '0;
                    r_accv  <= '0;
                    r_saddr <= '0;
                    r_state <= S_J_RD;
                end
                S_J_RD: r_state <= S_P0;
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_acc   <= r_prod;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_ru    <= sat32((SAT_W'(r_acc) - SAT_W'(r_prod)) >>> 24);
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_acc   <= r_prod;
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_rv    <= sat32((SAT_W'(r_acc) + SAT_W'(r_prod)) >>> 24);
                    r_state <= S_PDIV;
                end
                S_PDIV: begin
                    if (div_done) begin
                        r_rr    <= div_q;
                        r_state <= S_P5;
                    end
                end
                S_P5: r_state <= S_P6;
                S_P6: begin
                    r_eu    <= sat32(SAT_W'(mulq(r_prod)) - SAT_W'(r_ui));
                    r_state <= S_P7;
                end
                S_P7: begin
                    r_ev    <= sat32(SAT_W'(mulq(r_prod)) - SAT_W'(r_vi));
                    r_state <= S_P8;
                end
                S_P8: begin
                    r_accu  <= r_accu + ACC_W'(mulq(r_prod));
                    r_state <= S_P9;
                end
                S_P9: begin
                    r_accv  <= r_accv + ACC_W'(mulq(r_prod));
                    r_paddr <= r_paddr + 1'b1;
                    if (s_last) begin
                        r_state <= S_T0;
                    end else begin
                        r_saddr <= r_saddr + 1'b1;
                        r_state <= S_J_RD;
                    end
                end
                S_T0: r_state <= S_T1;
                S_T1: begin
                    r_cu    <= mulq(r_prod);
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_cv    <= mulq(r_prod);
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_sq    <= $unsigned(r_prod);
                    r_state <= S_T4;
                end
                S_T4: begin
                    r_sq    <= r_sq + $unsigned(r_prod);
                    r_state <= S_T5;
                end
                S_T5: r_state <= S_TDIV;
                S_TDIV: begin
                    if (div_done) begin
                        r_temp  <= sat32(SAT_W'(div_q) - SAT_W'(i_cfg.sigma));
                        r_state <= S_T6;
                    end
                end
                S_T6: r_state <= S_T7;
                S_T7: begin
                    r_lt    <= mulq(r_prod);
                    r_state <= S_T8;
                end
                S_T8: begin
                    r_dacc  <= 34'sd0 - 34'(mulq(r_prod));
                    r_state <= S_T9;
                end
                S_T9: begin
                    r_du    <= sat32(SAT_W'(r_dacc) - SAT_W'(mulq(r_prod)) + SAT_W'(r_cu));
                    r_state <= S_T10;
                end
                S_T10: begin
                    r_dacc  <= 34'(mulq(r_prod));
                    r_state <= S_T11;
                end
                S_T11: begin
                    r_dv    <= sat32(SAT_W'(r_dacc) - SAT_W'(mulq(r_prod)) + SAT_W'(r_cv));
                    r_state <= S_T12;
                end
                S_T12: begin
                    r_nu    <= sat32(SAT_W'(r_ui) + SAT_W'(mulq(r_prod)));
                    r_state <= S_T13;
                end
                S_T13: begin
                    r_nv    <= sat32(SAT_W'(r_vi) + SAT_W'(mulq(r_prod)));
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!report || out_free) begin
                        if (report) begin
                            r_mvalid <= 1'b1;
                            r_mdata  <= {5'd0, r_nv, r_nu, 3'(r_i)};
                            r_mlast  <= 32'(r_i) == REPORT_N - 1;
                        end
                        if (i_last) begin
                            r_saddr <= '0;
                            r_state <= S_C_RD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_saddr <= r_i + 1'b1;
                            r_state <= S_I_RD;
                        end
                    end
                end
                S_C_RD: r_state <= S_C_WR;
                S_C_WR: begin
                    if (s_last) begin
                        r_i     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_saddr <= r_saddr + 1'b1;
                        r_state <= S_C_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tlast  = r_mlast;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE))
        else $error("command taken outside idle");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_mlast) |-> (32'(r_mdata[2:0]) == REPORT_N - 1))
        else $error("last flag on wrong oscillator");

    a_commit_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_C_RD) && (r_saddr == '0) |-> $past(r_state == S_EMIT))
        else $error("commit started before all states computed");

endmodule

>>> hdl/coupled_hopf_oscillator_network.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coupled_hopf_oscillator_network
// Central pattern generator of coupled Hopf oscillators in Q8.24 arithmetic.
// ----------------------------------------------------------------------------
// Pair-table and oscillator-state writes are accepted into a four-entry
// command queue and executed one at a time by the back end. A step request
// walks all oscillator pairs through one shared multiplier and one
// bit-serial divider, which takes most of its run time. Results come out
// in oscillator order with tlast on the final one, after which the new
// states are committed. Requests behind a step wait in the queue while it
// runs.
module coupled_hopf_oscillator_network import chon_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // row[2:0], col[5:3], weight[37:6], cos_phase[63:38], sin_phase[89:64],
    // state_u[121:90], state_v[153:122], radius[184:154], zero fill above
    input  logic [IN_W-1:0]      s_axis_tdata,
    // func[1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // osc_index[2:0], new_u[34:3], new_v[66:35], zero fill above
    output logic [OUT_W-1:0]     m_axis_tdata,
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic full;
    logic head_valid;
    logic pop;

    chon_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg         (cfg),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    chon_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    chon_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head_cmd),
        .o_cmd_pop     (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
